[rtl/ffa_pkg.sv]
`timescale 1ns / 1ps

package ffa_pkg;

    // bitmap word: 16 blocks per RAM word
    localparam int WORD_BITS = 16;
    localparam int WORD_LOG  = 4;

    // field widths
    localparam int WANT_W    = 11;
    localparam int START_W   = 10;
    localparam int RUN_SUM_W = WANT_W + 1;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_SCAN    = 6'b000100,
        S_MARK_RD = 6'b001000,
        S_MARK_WR = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

endpackage

[rtl/ffa_ram.sv]
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/first_fit_contiguous_block_allocator_core.sv]
`timescale 1ns / 1ps
// Zero-length requests skip the scan; others scan one 16-block bitmap word per cycle
//   from the word holding the first non-reserved block, then a grant marks each word of
//   the run by read-modify-write (S_MARK_RD, then S_MARK_WR).
// Throughput: one request at a time; s_axis_tready is high only while the sequencer idles.
// Reset: synchronous, active-low. After reset a clearing pass writes every bitmap word with
//   reserved and out-of-range blocks marked used; no beat is taken during the pass.

module first_fit_contiguous_block_allocator_core #(
    parameter int TOTAL_BLOCKS    = 1024,
    parameter int RESERVED_BLOCKS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ffa_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [10:0] blocks_wanted, [15:11] zero
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ffa_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [9:0] start_block, [15:10] zero
    output logic                          m_axis_tuser    // [0] granted
);

    localparam int WB      = ffa_pkg::WORD_BITS;
    localparam int WL      = ffa_pkg::WORD_LOG;
    localparam int NWORDS  = (TOTAL_BLOCKS + WB - 1) / WB;
    localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IDXW    = AW + WL;
    localparam int IW      = ((IDXW > ffa_pkg::WANT_W) ? IDXW : ffa_pkg::WANT_W) + 1;
    localparam int RES_LIM = (RESERVED_BLOCKS < TOTAL_BLOCKS) ? RESERVED_BLOCKS : TOTAL_BLOCKS;
    localparam int START_WORD_I = (RES_LIM >= TOTAL_BLOCKS) ? 0 : (RES_LIM / WB);

    localparam logic [AW-1:0] LAST_WORD  = AW'(NWORDS - 1);
    localparam logic [AW-1:0] START_WORD = AW'(START_WORD_I);
    localparam logic [31:0]   RES_LIM32  = 32'(RES_LIM);
    localparam logic [31:0]   TOTAL32    = 32'(TOTAL_BLOCKS);

    localparam int RSW = ffa_pkg::RUN_SUM_W;

    // sequencer and scan state
    ffa_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr_word, n_clr_word;
    logic [AW-1:0]   r_iss_word, n_iss_word;   // next word to read
    logic            r_iss_more, n_iss_more;
    logic            r_pend, n_pend;           // read data valid this cycle
    logic [AW-1:0]   r_ev_word, n_ev_word;     // word whose data arrives
    logic [AW-1:0]   r_mk_word, n_mk_word;
    logic            r_out_valid, n_out_valid;

    // payload
    logic [ffa_pkg::WANT_W-1:0]  r_want, n_want;
    logic [ffa_pkg::WANT_W-1:0]  r_run, n_run;    // free run carried in from lower words
    logic [IDXW-1:0]             r_start, n_start;
    logic [IDXW-1:0]             r_end, n_end;
    logic                        r_grant, n_grant;
    logic                        r_out_grant, n_out_grant;
    logic [ffa_pkg::START_W-1:0] r_out_start, n_out_start;

    // bitmap RAM
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    ffa_pkg::t_word      ram_wdata;
    logic [AW-1:0]       ram_raddr;
    ffa_pkg::t_word      ram_rdata;

    ffa_ram #(
        .WIDTH (WB),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // reset image of the word being cleared: reserved and out-of-range blocks used
    ffa_pkg::t_word init_word;
    always_comb begin
        logic [31:0] gi;
        init_word = '0;
        for (int b = 0; b < WB; b++) begin
            gi = 32'({r_clr_word, WL'(b)});
            init_word[b] = (gi < RES_LIM32) || (gi >= TOTAL32);
        end
    end

    // per-bit run length ending at each bit of the word on the read port
    logic [RSW-1:0] run_at [WB];
    logic [WB-1:0]  hit_vec;
    logic           hit;
    logic [WL-1:0]  hit_k;
    always_comb begin
        logic          any_used;
        logic [WL-1:0] last_used;
        for (int k = 0; k < WB; k++) begin
            any_used  = 1'b0;
            last_used = '0;
            for (int j = 0; j <= k; j++) begin
                if (ram_rdata[j]) begin
                    any_used  = 1'b1;
                    last_used = WL'(j);
                end
            end
            if (any_used) begin
                run_at[k] = RSW'(k) - RSW'(last_used);
            end else begin
                run_at[k] = RSW'(r_run) + RSW'(k + 1);
            end
            hit_vec[k] = !ram_rdata[k] && (run_at[k] >= RSW'(r_want));
        end
    end

    // lowest bit where the run reaches the requested length
    always_comb begin
        hit_k = '0;
        for (int k = WB - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                hit_k = WL'(k);
            end
        end
        hit = |hit_vec;
    end

    logic [IDXW-1:0] hit_end;
    logic [IW-1:0]   hit_start_w;
    logic [IDXW-1:0] hit_start;
    assign hit_end     = {r_ev_word, hit_k};
    assign hit_start_w = IW'(hit_end) + IW'(1) - IW'(r_want);
    assign hit_start   = hit_start_w[IDXW-1:0];

    // bits of the word being marked that fall inside the granted run
    ffa_pkg::t_word mark_mask;
    always_comb begin
        logic [IDXW-1:0] gm;
        mark_mask = '0;
        for (int b = 0; b < WB; b++) begin
            gm = {r_mk_word, WL'(b)};
            mark_mask[b] = (gm >= r_start) && (gm <= r_end);
        end
    end

    logic [IW-1:0] start_ext;
    assign start_ext = IW'(r_start);

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_clr_word  = r_clr_word;
        n_iss_word  = r_iss_word;
        n_iss_more  = r_iss_more;
        n_pend      = 1'b0;
        n_ev_word   = r_ev_word;
        n_mk_word   = r_mk_word;
        n_want      = r_want;
        n_run       = r_run;
        n_start     = r_start;
        n_end       = r_end;
        n_grant     = r_grant;
        n_out_grant = r_out_grant;
        n_out_start = r_out_start;
        n_out_valid = r_out_valid && !m_axis_tready;

        ram_we    = 1'b0;
        ram_waddr = r_clr_word;
        ram_wdata = init_word;
        ram_raddr = r_iss_word;

        case (r_state)
            ffa_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                if (r_clr_word == LAST_WORD) begin
                    n_state = ffa_pkg::S_IDLE;
                end else begin
                    n_clr_word = r_clr_word + 1'b1;
                end
            end
            ffa_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_want = s_axis_tdata[ffa_pkg::WANT_W-1:0];
                    n_run  = '0;
                    if (s_axis_tdata[ffa_pkg::WANT_W-1:0] == '0) begin
                        n_grant = 1'b0;
                        n_start = '0;
                        n_state = ffa_pkg::S_DONE;
                    end else begin
                        n_iss_word = START_WORD;
                        n_iss_more = 1'b1;
                        n_ev_word  = START_WORD;
                        n_state    = ffa_pkg::S_SCAN;
                    end
                end
            end
            ffa_pkg::S_SCAN: begin
                // keep one read in flight ahead of the evaluation
                n_pend = r_iss_more;
                if (r_iss_more) begin
                    if (r_iss_word == LAST_WORD) begin
                        n_iss_more = 1'b0;
                    end else begin
                        n_iss_word = r_iss_word + 1'b1;
                    end
                end
                if (r_pend) begin
                    if (hit) begin
                        n_grant   = 1'b1;
                        n_start   = hit_start;
                        n_end     = hit_end;
                        n_mk_word = hit_start[IDXW-1:WL];
                        n_state   = ffa_pkg::S_MARK_RD;
                    end else begin
                        n_run = run_at[WB-1][ffa_pkg::WANT_W-1:0];
                        if (r_ev_word == LAST_WORD) begin
                            n_grant = 1'b0;
                            n_start = '0;
                            n_state = ffa_pkg::S_DONE;
                        end else begin
                            n_ev_word = r_ev_word + 1'b1;
                        end
                    end
                end
            end
            ffa_pkg::S_MARK_RD: begin
                ram_raddr = r_mk_word;
                n_state   = ffa_pkg::S_MARK_WR;
            end
            ffa_pkg::S_MARK_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_mk_word;
                ram_wdata = ram_rdata | mark_mask;
                if (r_mk_word == r_end[IDXW-1:WL]) begin
                    n_state = ffa_pkg::S_DONE;
                end else begin
                    n_mk_word = r_mk_word + 1'b1;
                    n_state   = ffa_pkg::S_MARK_RD;
                end
            end
            ffa_pkg::S_DONE: begin
                // hand off to the output register once it is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_grant = r_grant;
                    n_out_start = start_ext[ffa_pkg::START_W-1:0];
                    n_state     = ffa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffa_pkg::S_CLEAR;
            r_clr_word  <= '0;
            r_iss_word  <= '0;
            r_iss_more  <= 1'b0;
            r_pend      <= 1'b0;
            r_ev_word   <= '0;
            r_mk_word   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_word  <= n_clr_word;
            r_iss_word  <= n_iss_word;
            r_iss_more  <= n_iss_more;
            r_pend      <= n_pend;
            r_ev_word   <= n_ev_word;
            r_mk_word   <= n_mk_word;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want      <= n_want;
        r_run       <= n_run;
        r_start     <= n_start;
        r_end       <= n_end;
        r_grant     <= n_grant;
        r_out_grant <= n_out_grant;
        r_out_start <= n_out_start;
    end

    assign s_axis_tready = (r_state == ffa_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_grant;
    assign m_axis_tdata  = {{(ffa_pkg::M_TDATA_W - ffa_pkg::START_W){1'b0}}, r_out_start};

`ifndef SYNTHESIS
    // nothing is taken before the bitmap image is in place
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // carried run never reaches the request while scanning
    a_run_below_want: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_SCAN) |-> (r_run < r_want))
        else $error("carried run reached request without a grant");

    // marking walks only inside the granted run
    a_mark_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ffa_pkg::S_MARK_RD) || (r_state == ffa_pkg::S_MARK_WR))
        |-> ((r_mk_word <= r_end[IDXW-1:WL]) && (r_start <= r_end)))
        else $error("mark word outside granted run");

    // a grant never starts inside the reserved area
    a_grant_past_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ffa_pkg::S_DONE) && r_grant) |-> (32'(r_start) >= RES_LIM32))
        else $error("grant inside reserved blocks");

    // denied results carry a zero start
    a_deny_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_grant) |-> (r_out_start == '0))
        else $error("denied result with nonzero start");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int NUM_BLOCKS  = 1024;
    localparam int RSVD_BLOCKS = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYC  = 200;   // > worst-case scan + mark at defaults
    localparam int MAX_REPORTS = 10;

    localparam int WANT_W    = ffa_pkg::WANT_W;
    localparam int START_W   = ffa_pkg::START_W;
    localparam int S_TDATA_W = ffa_pkg::S_TDATA_W;
    localparam int M_TDATA_W = ffa_pkg::M_TDATA_W;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_block;
    } t_alloc_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // shadow copy of the usage bitmap
    logic                 block_used [NUM_BLOCKS];
    int                   blocks_free;
    t_alloc_result        alloc_expect_q [$];
    t_alloc_result        due_res;

    int  mismatch_cnt = 0;
    int  n_requests   = 0;
    int  n_granted    = 0;
    int  n_denied     = 0;
    int  top_start    = 0;
    int  cycle_cnt    = 0;
    bit  src_idle_en  = 1'b1;
    bit  sink_idle_en = 1'b1;
    int  hold_left    = 0;   // long receiver hold-off, in cycles
    int  stall_left   = 0;

    first_fit_contiguous_block_allocator_core #(
        .TOTAL_BLOCKS    (NUM_BLOCKS),
        .RESERVED_BLOCKS (RSVD_BLOCKS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, alloc_expect_q.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic void clear_bitmap();
        for (int i = 0; i < NUM_BLOCKS; i++)
            block_used[i] = (i < RSVD_BLOCKS);
        blocks_free = (RSVD_BLOCKS < NUM_BLOCKS) ? NUM_BLOCKS - RSVD_BLOCKS : 0;
    endfunction

    // first fit: lowest free run of exactly 'want' blocks above the reserved area
    function automatic t_alloc_result first_fit(input logic [WANT_W-1:0] want);
        t_alloc_result res;
        int            run;
        int            head;
        res  = '0;
        run  = 0;
        head = 0;
        if (want == '0)
            return res;
        for (int i = RSVD_BLOCKS; i < NUM_BLOCKS; i++) begin
            if (!block_used[i]) begin
                if (run == 0)
                    head = i;
                run++;
                if (run == int'(want)) begin
                    for (int j = head; j <= i; j++)
                        block_used[j] = 1'b1;
                    blocks_free      -= run;
                    res.granted      = 1'b1;
                    res.start_block  = head[START_W-1:0];
                    return res;
                end
            end else begin
                run = 0;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch %s: expected 0x%0h, got 0x%0h (cycle %0d)",
                     what, exp_v, got_v, cycle_cnt);
    endtask

    // result checker: every accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (alloc_expect_q.size() == 0) begin
                report_mismatch("unexpected result, tdata", 0, int'(m_axis_tdata));
            end else begin
                due_res = alloc_expect_q.pop_front();
                if (m_axis_tuser !== due_res.granted)
                    report_mismatch("granted", int'(due_res.granted), int'(m_axis_tuser));
                if (m_axis_tdata !== {{(M_TDATA_W-START_W){1'b0}}, due_res.start_block})
                    report_mismatch("start_block", int'(due_res.start_block),
                                    int'(m_axis_tdata));
            end
        end
    end

    // receiver: random short stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one request beat; valid stays up for a following beat unless a gap is inserted
    task automatic send_request(input logic [WANT_W-1:0] want);
        t_alloc_result res;
        if (src_idle_en && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-WANT_W){1'b0}}, want};
        do @(posedge i_clk); while (!s_axis_tready);
        res = first_fit(want);
        alloc_expect_q.push_back(res);
        n_requests++;
        if (res.granted) begin
            n_granted++;
            if (int'(res.start_block) > top_start)
                top_start = int'(res.start_block);
        end else begin
            n_denied++;
        end
    endtask

    // sender pauses until every outstanding result is back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (alloc_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        send_request(11'd0);                        // zero request
        send_request(11'd2047);                     // beyond bitmap, all bits set
        send_request(11'd1024);                     // whole bitmap, reserved area in way
        send_request(11'(blocks_free + 1));         // one more than free
        send_request(11'd1);                        // first free block
        send_request(11'd7);                        // fills to the word edge
        send_request(11'd16);                       // fills one whole word
        send_request(11'd3);
        send_request(11'd33);                       // spans several words
        send_request(11'd0);
        send_request(11'b010_1010_1010);            // alternating bits, large
        send_request(11'b101_0101_0101);
        send_request(11'd2);
        wait_drain();
    endtask

    task automatic test_random_mix(input int n_items);
        logic [WANT_W-1:0] want;
        int                pick;
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) begin
                src_idle_en  = $urandom_range(0, 3) != 0;
                sink_idle_en = $urandom_range(0, 3) != 0;
            end
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                want = 11'($urandom_range(1, 2));
            else if (pick == 6)
                want = '0;
            else if (pick == 7 && blocks_free < 2047)
                want = 11'($urandom_range(blocks_free + 1, 2047));   // sure deny
            else if (pick == 8 && blocks_free < 2047)
                want = 11'(blocks_free + 1);                          // just too long
            else
                want = 11'($urandom_range(1, 8));
            send_request(want);
        end
        wait_drain();
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_backpressure();
        src_idle_en  = 1'b0;
        hold_left    = 400;
        for (int k = 0; k < 6; k++)
            send_request(11'($urandom_range(1, 3)));
        wait_drain();
        src_idle_en  = 1'b1;
    endtask

    // no idling: take everything but the top block, then the top block alone
    task automatic test_fill_to_top();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        if (blocks_free >= 2)
            send_request(11'(blocks_free - 1));
        send_request(11'd1);                        // top block when it is free
        send_request(11'd1);                        // full: denied
        send_request(11'd0);
        send_request(11'd2047);
        wait_drain();
    endtask

    initial begin
        clear_bitmap();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_mix(470);
        test_backpressure();
        test_fill_to_top();

        repeat (SETTLE_CYC) @(posedge i_clk);

        if (alloc_expect_q.size() != 0)
            report_mismatch("results missing, count", 0, alloc_expect_q.size());

        $display("requests %0d: %0d granted, %0d denied; highest start block %0d",
                 n_requests, n_granted, n_denied, top_start);
        $display("covered zero and oversize requests, word-spanning runs, long stall, full fill");
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("status: fail");
        end
        $finish;
    end

endmodule
